>>> rtl/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
`default_nettype none
package bba_pkg;

  localparam int ADDR_W          = 32;
  localparam int WORD_BITS       = 32;
  localparam int WORD_IDX_W      = 5;
  localparam int FREE_W          = 11;
  localparam int DEF_NUM_BLOCKS  = 1024;
  localparam int DEF_BLOCK_BYTES = 256;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FRD,
    S_FCHK,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    clr_wr;
    logic    load;
    logic    div_init;
    logic    div_step;
    logic    scan_rd;
    logic    alloc_wr;
    logic    mul;
    logic    add;
    logic    free_rd;
    logic    free_wr;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic full;
    logic addr_bad;
    logic word_hit;
    logic rem_nz;
    logic bit_used;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/bba_ctrl.sv
// Sequencing state machine for the block bitmap allocator.
`default_nettype none
module bba_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t      cmd
);

  bba_pkg::state_t  state, state_next;
  bba_pkg::status_t resp, resp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_CLEAR;
      resp  <= bba_pkg::ST_OK;
    end else begin
      state <= state_next;
      resp  <= resp_next;
    end
  end

  always_comb begin
    state_next     = state;
    resp_next      = resp;
    s_tready       = 1'b0;
    cmd            = '0;
    cmd.out_status = resp;
    unique case (state)
      bba_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = bba_pkg::S_DECODE;
        end
      end
      bba_pkg::S_DECODE: begin
        if (!stat.is_free) begin
          if (stat.full) begin
            resp_next  = bba_pkg::ST_FULL;
            state_next = bba_pkg::S_RESP;
          end else begin
            state_next = bba_pkg::S_SCAN;
          end
        end else if (stat.addr_bad) begin
          resp_next  = bba_pkg::ST_BAD;
          state_next = bba_pkg::S_RESP;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = bba_pkg::S_DIV;
        end
      end
      bba_pkg::S_SCAN: begin
        if (stat.word_hit) begin
          cmd.alloc_wr = 1'b1;
          state_next   = bba_pkg::S_MUL;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      bba_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = bba_pkg::S_ADD;
      end
      bba_pkg::S_ADD: begin
        cmd.add    = 1'b1;
        resp_next  = bba_pkg::ST_OK;
        state_next = bba_pkg::S_RESP;
      end
      bba_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = bba_pkg::S_FRD;
      end
      bba_pkg::S_FRD: begin
        if (stat.rem_nz) begin
          resp_next  = bba_pkg::ST_BAD;
          state_next = bba_pkg::S_RESP;
        end else begin
          cmd.free_rd = 1'b1;
          state_next  = bba_pkg::S_FCHK;
        end
      end
      bba_pkg::S_FCHK: begin
        if (stat.bit_used) begin
          cmd.free_wr = 1'b1;
          resp_next   = bba_pkg::ST_OK;
        end else begin
          resp_next = bba_pkg::ST_BAD;
        end
        state_next = bba_pkg::S_RESP;
      end
      bba_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bba_pkg::S_IDLE;
        end
      end
      default: state_next = bba_pkg::S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/bba_datapath.sv
// Bitmap memory, free counter, address-to-index conversion, multiplier and result register.
`default_nettype none
module bba_datapath #(
  parameter int NUM_BLOCKS  = bba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bba_pkg::ADDR_W-1:0]  cfg_wdata,
  input  wire logic [bba_pkg::ADDR_W-1:0]  s_tdata,
  input  wire logic [0:0]                  s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [47:0]                      m_tdata,
  input  wire bba_pkg::dp_cmd_t            cmd,
  output bba_pkg::dp_stat_t                stat
);

  localparam int WB   = bba_pkg::WORD_BITS;
  localparam int WIW  = bba_pkg::WORD_IDX_W;
  localparam int AW   = bba_pkg::ADDR_W;
  localparam int ROWS = (NUM_BLOCKS + WB - 1) / WB;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW   = RW + WIW;
  localparam int CNTW = $clog2(NUM_BLOCKS + 1);
  localparam int EW   = (CNTW > bba_pkg::FREE_W) ? CNTW : bba_pkg::FREE_W;
  localparam longint unsigned LIMIT_L = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
  localparam logic [AW:0]   LIMIT = (AW + 1)'(LIMIT_L);
  localparam logic [AW-1:0] BB    = AW'(BLOCK_BYTES);

  // position of the lowest set bit
  function automatic int low_one(input logic [AW-1:0] v);
    int n;
    n = 0;
    for (int b = AW - 1; b >= 0; b--) begin
      if (v[b]) n = b;
    end
    return n;
  endfunction

  // inverse of an odd value modulo 2^AW (Newton steps, bits double each pass)
  function automatic logic [AW-1:0] odd_inverse(input logic [AW-1:0] o);
    logic [AW-1:0] x;
    x = o;
    for (int i = 0; i < 5; i++) x = x * (AW'(2) - o * x);
    return x;
  endfunction

  // BLOCK_BYTES = 2^TZ * ODD; an exact multiple of ODD times INV gives the quotient,
  // anything else lands at or above NUM_BLOCKS
  localparam int            TZ   = low_one(BB);
  localparam logic [AW-1:0] ODD  = BB >> TZ;
  localparam logic [AW-1:0] INV  = odd_inverse(ODD);
  localparam logic [AW-1:0] MASK = AW'((longint'(1) << TZ) - 1);

  // contents written to one row by the clearing pass: block zero and padding past the end read used
  function automatic logic [WB-1:0] init_word(input logic [RW-1:0] row);
    logic [WB-1:0]   w;
    longint unsigned g;
    for (int b = 0; b < WB; b++) begin
      g    = longint'(row) * WB + b;
      w[b] = (g == 0) || (g >= NUM_BLOCKS);
    end
    return w;
  endfunction

  logic [WB-1:0] mem [ROWS];
  logic [WB-1:0] rdata;

  logic [AW-1:0]   data_base;
  logic [AW-1:0]   req_addr;
  logic            req_free;
  logic [CNTW-1:0] count;
  logic [RW-1:0]   clr_row;
  logic [RW-1:0]   scan_row;
  logic [RW-1:0]   data_row;
  logic            rd_vld;
  logic [XW-1:0]   idx;
  logic [AW-1:0]   prod;
  logic [AW-1:0]   granted;
  logic [AW-1:0]   rem;
  logic [AW-1:0]   quo;

  logic [1:0]      o_status;
  logic [AW-1:0]   o_granted;
  logic [bba_pkg::FREE_W-1:0] o_free;

  logic [AW-1:0]   off;
  logic [XW-1:0]   qx;
  logic [RW-1:0]   frow;
  logic [WIW-1:0]  fbit;
  logic [WIW-1:0]  hit_bit;
  logic [EW-1:0]   count_ext;

  logic            we, re;
  logic [RW-1:0]   wa, ra;
  logic [WB-1:0]   wd;

  assign off       = req_addr - data_base;
  assign qx        = quo[XW-1:0];
  assign frow      = qx[XW-1:WIW];
  assign fbit      = qx[WIW-1:0];
  assign count_ext = EW'(count);

  // lowest clear bit of the word just read
  always_comb begin
    hit_bit = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!rdata[i]) hit_bit = WIW'(i);
    end
  end

  always_comb begin
    we = 1'b0;
    wa = clr_row;
    wd = init_word(clr_row);
    re = 1'b0;
    ra = scan_row;
    if (cmd.alloc_wr) begin
      we = 1'b1;
      wa = data_row;
      wd = rdata | (WB'(1) << hit_bit);
    end else if (cmd.free_wr) begin
      we = 1'b1;
      wa = frow;
      wd = rdata & ~(WB'(1) << fbit);
    end else if (cmd.clr_wr) begin
      we = 1'b1;
    end
    if (cmd.scan_rd) begin
      re = 1'b1;
    end else if (cmd.free_rd) begin
      re = 1'b1;
      ra = frow;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= '0;
      count     <= CNTW'(NUM_BLOCKS - 1);
      clr_row   <= '0;
      rd_vld    <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) data_base <= cfg_wdata;
      if (cmd.clr_wr) clr_row <= clr_row + RW'(1);
      if (cmd.alloc_wr) count <= count - CNTW'(1);
      else if (cmd.free_wr) count <= count + CNTW'(1);
      rd_vld <= cmd.scan_rd;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_addr <= s_tdata;
      req_free <= (s_tuser[0] == bba_pkg::CMD_FREE);
      scan_row <= '0;
      granted  <= '0;
    end
    if (cmd.scan_rd) begin
      scan_row <= scan_row + RW'(1);
      data_row <= scan_row;
    end
    if (cmd.alloc_wr) idx <= {data_row, hit_bit};
    if (cmd.mul) prod <= AW'(idx) * BB;
    if (cmd.add) granted <= data_base + prod;
    if (cmd.div_init) rem <= off;
    if (cmd.div_step) quo <= (rem >> TZ) * INV;
    if (cmd.out_load) begin
      o_status  <= cmd.out_status;
      o_granted <= granted;
      o_free    <= count_ext[bba_pkg::FREE_W-1:0];
    end
  end

  assign m_tdata = {3'b000, o_free, o_granted, o_status};

  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_row == RW'(ROWS - 1));
    stat.is_free  = req_free;
    stat.full     = (count == '0);
    stat.addr_bad = (req_addr < data_base) || ({1'b0, off} >= LIMIT);
    stat.word_hit = rd_vld && !(&rdata);
    // misaligned, or not a whole multiple of the odd factor
    stat.rem_nz   = ((rem & MASK) != '0) || (quo >= AW'(NUM_BLOCKS));
    stat.bit_used = rdata[fbit];
    stat.out_free = !m_tvalid || m_tready;
  end

endmodule
`default_nettype wire

>>> rtl/block_bitmap_allocator_unit.sv
// Top level of the first-fit block bitmap allocator.
// The unit keeps one used bit per block in a memory of 32-bit rows plus a free-block
// counter. A request carries a command on s_tuser (allocate or free) and, for a free,
// the block address on s_tdata. Allocate scans the rows from the bottom, one row read
// per cycle, takes the lowest clear bit, marks it used and returns
// data_base + index * BLOCK_BYTES. Free subtracts data_base and turns the offset into
// a block index by a multiply with the inverse of the odd factor of BLOCK_BYTES, which
// is exact for whole multiples and lands out of range for anything else; it then
// checks alignment, range and that the block is in use, and clears its bit. Every
// request gives exactly one result.
// Sequence up to the load of the result: an allocate passes DECODE, SCAN, MUL, ADD and
// RESP; SCAN reads rows from 0 up to the row holding the first free block (at most
// ceil(NUM_BLOCKS/32) - 1) through the single memory read port. An allocate on a full
// map goes from DECODE straight to RESP. A free passes DECODE, DIV, FRD, FCHK and RESP;
// a misaligned address inside the map leaves at FRD, an address below data_base or
// past the last block at DECODE. The unit is ready again in the cycle after the result
// is loaded. One request is in flight at a time; a new request is taken while the
// previous result still waits in the output register. After reset the unit runs a
// clearing pass over the ceil(NUM_BLOCKS/32) rows (32 at default), during which
// s_tready stays low; block zero comes up used. data_base may be written through
// cfg_we/cfg_wdata only while no request is in flight.
`default_nettype none
module block_bitmap_allocator_unit #(
  parameter int NUM_BLOCKS  = bba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration: data_base
  input  wire logic                       cfg_we,
  input  wire logic [bba_pkg::ADDR_W-1:0] cfg_wdata,
  // request channel
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [bba_pkg::ADDR_W-1:0] s_tdata,   // [31:0] block_address
  input  wire logic [0:0]                 s_tuser,   // [0] cmd (0 allocate, 1 free)
  // result channel
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [47:0]                     m_tdata    // [1:0] status, [33:2] granted_address,
                                                     // [44:34] free_blocks, [47:45] zero
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire
